// ----- rtl/segment_polygon_crosspoints_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the segment / polygon crosspoint unit
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_POLYGON_CROSSPOINTS_UNIT_ASSERT_SVH
`define SEGMENT_POLYGON_CROSSPOINTS_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SPC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("crosspoint unit check failed");
`define SPC_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("crosspoint unit check failed");
`else
`define SPC_ASSERT(lbl, clk, rstn, prop)
`define SPC_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ----- rtl/spc_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment / polygon crosspoint package
// Widths, constants, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int PROD_W  = 66;
  localparam int WIDE_W  = 67;
  localparam int NUM_W   = 100;
  localparam int QUO_W   = 34;
  localparam int ACC_W   = 76;
  localparam int STEP_W  = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [WIDE_W-1:0] PARALLEL_MIN = 67'sd430;
  localparam logic [8:0] DUP_D2_MAX = 9'd42;
  localparam logic signed [DIFF_W-1:0] DUP_SPAN = 33'sd7;

  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAY_SEL = 3'd4;

  typedef enum logic [16:0] {
    S_IDLE    = 17'b00000000000000001,
    S_SETUP   = 17'b00000000000000010,
    S_MUL     = 17'b00000000000000100,
    S_FIX     = 17'b00000000000001000,
    S_CHECK   = 17'b00000000000010000,
    S_RAY     = 17'b00000000000100000,
    S_RAYTST  = 17'b00000000001000000,
    S_XMUL    = 17'b00000000010000000,
    S_XABS    = 17'b00000000100000000,
    S_XSAT    = 17'b00000001000000000,
    S_XDIV    = 17'b00000010000000000,
    S_XFIN    = 17'b00000100000000000,
    S_DUPRD   = 17'b00001000000000000,
    S_DUPCMP  = 17'b00010000000000000,
    S_EMIT    = 17'b00100000000000000,
    S_EDGEEND = 17'b01000000000000000,
    S_MARK    = 17'b10000000000000000
  } state_e;

endpackage

// ----- rtl/segment_polygon_crosspoints_unit.sv -----
// ----------------------------------------------------------------------------
// Segment / polygon crosspoint unit
// Intersects each polygon edge with a configured segment or ray.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                   Payload
// vertex    in         in_valid_i / in_ready_o      vertex_x_i, vertex_y_i, final_vertex_i
// cross     out        out_valid_o / out_ready_i    cross_x_o, cross_y_o, point_valid_o,
//                                                   run_end_o
// config    in         cfg_we_i                     cfg_idx_i, cfg_wdata_i
// A crossing edge shares the 33x33 multiplier, the 34-step divider and the one memory
// read port, and reads back the stored points for the duplicate check.
// An edge that misses, or fails the ray test, ends without a division.
// S_IDLE accepts a vertex; later ones start an edge, a final one adds the closing edge and end marker.
// Reset clears all control state; the point memory needs no clearing.
// The sequencer waits when a result is ready and the output register is full.
// ----------------------------------------------------------------------------
module segment_polygon_crosspoints_unit
  import spc_pkg::*;
#(
  parameter int MAX_FOUND = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [COORD_W-1:0]           cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_W-1:0]    vertex_x_i,
  input  logic signed [COORD_W-1:0]    vertex_y_i,
  input  logic                         final_vertex_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_W-1:0]    cross_x_o,
  output logic signed [COORD_W-1:0]    cross_y_o,
  output logic                         point_valid_o,
  output logic                         run_end_o
);

`include "segment_polygon_crosspoints_unit_assert.svh"

  localparam int CW = $clog2(MAX_FOUND + 1);
  localparam int AW = $clog2(MAX_FOUND);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FOUND);

  state_e state_q, state_d;

  logic signed [COORD_W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic ray_q;

  logic signed [COORD_W-1:0] cur_x_q, cur_y_q, prior_x_q, prior_y_q, first_x_q, first_y_q;
  logic signed [COORD_W-1:0] cur_x_d, cur_y_d, prior_x_d, prior_y_d, first_x_d, first_y_d;
  logic fin_q, fin_d, have_prior_q, have_prior_d, edge_q, edge_d, coord_q, coord_d;
  logic [CW-1:0] found_cnt_q, found_cnt_d, idx_q, idx_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic signed [DIFF_W-1:0] sx_q, sy_q, rx_q, ry_q, dx_q, dy_q;
  logic signed [DIFF_W-1:0] sx_d, sy_d, rx_d, ry_d, dx_d, dy_d;
  logic signed [WIDE_W-1:0] r_q, u_q, t_q, r_d, u_d, t_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [NUM_W-1:0]  n_q, n_d;
  logic [NUM_W-2:0]         nabs_q, nabs_d;
  logic neg_q, neg_d, sat_q, sat_d;
  logic [PROD_W-1:0]        rem_q, rem_d;
  logic [QUO_W-1:0]         nlow_q, nlow_d, quo_q, quo_d;
  logic signed [COORD_W-1:0] x_q, x_d, y_q, y_d;

  logic signed [DIFF_W-1:0] ma, mb;
  logic signed [PROD_W-1:0] prod_q;

  logic [2*COORD_W-1:0] mem [MAX_FOUND];
  logic [2*COORD_W-1:0] rd_q;
  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr;

  logic out_valid_q, out_valid_d, pv_q, pv_d, re_q, re_d;
  logic signed [COORD_W-1:0] ox_q, ox_d, oy_q, oy_d;
  logic slot_free;

  logic signed [COORD_W-1:0] pe_x, pe_y, ce_x, ce_y;
  logic signed [PROD_W:0]   prod_x;
  logic signed [ACC_W-1:0]  uext, rext, term;
  logic [WIDE_W-1:0]        rem2;
  logic                     ge, rnd, near;
  logic [QUO_W:0]           qr;
  logic signed [QUO_W+1:0]  sq;
  logic signed [QUO_W+2:0]  sum;
  logic signed [COORD_W-1:0] base, coord_val;
  logic signed [DIFF_W-1:0] ddx, ddy;
  logic signed [7:0]        dx2, dy2;
  logic [8:0]               d2;

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
      ray_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_X: start_x_q <= cfg_wdata_i;
        CFG_START_Y: start_y_q <= cfg_wdata_i;
        CFG_END_X:   end_x_q   <= cfg_wdata_i;
        CFG_END_Y:   end_y_q   <= cfg_wdata_i;
        CFG_RAY_SEL: ray_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == S_XMUL) begin
      ma = coord_q ? sy_q : sx_q;
      case (step_q)
        6'd0: mb = {1'b0, u_q[31:0]};
        6'd1: mb = {1'b0, u_q[63:32]};
        6'd2: mb = {30'd0, u_q[66:64]};
        default: mb = '0;
      endcase
    end else begin
      case (step_q)
        6'd0: begin ma = rx_q; mb = sy_q; end
        6'd1: begin ma = ry_q; mb = sx_q; end
        6'd2: begin ma = dx_q; mb = ry_q; end
        6'd3: begin ma = dy_q; mb = rx_q; end
        6'd4: begin ma = dx_q; mb = sy_q; end
        6'd5: begin ma = dy_q; mb = sx_q; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= {x_q, y_q};
    end
    if (mem_re) begin
      rd_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_comb begin
    pe_x = edge_q ? cur_x_q : prior_x_q;
    pe_y = edge_q ? cur_y_q : prior_y_q;
    ce_x = edge_q ? first_x_q : cur_x_q;
    ce_y = edge_q ? first_y_q : cur_y_q;
    prod_x = {prod_q[PROD_W-1], prod_q};
    uext = {{(ACC_W-WIDE_W){u_q[WIDE_W-1]}}, u_q};
    rext = {{(ACC_W-WIDE_W){r_q[WIDE_W-1]}}, r_q};
    case (step_q)
      6'd0: term = uext <<< 6;
      6'd1: term = uext <<< 5;
      6'd2: term = uext <<< 2;
      6'd3: term = -(rext <<< 6);
      6'd4: term = -(rext <<< 5);
      6'd5: term = -(rext <<< 1);
      default: term = -rext;
    endcase
    rem2 = {rem_q, nlow_q[QUO_W-1]};
    ge   = rem2 >= {1'b0, r_q[PROD_W-1:0]};
    rnd  = {rem_q, 1'b0} >= {1'b0, r_q[PROD_W-1:0]};
    qr   = {1'b0, quo_q} + {{QUO_W{1'b0}}, rnd};
    sq   = neg_q ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
    base = coord_q ? start_y_q : start_x_q;
    sum  = {sq[QUO_W+1], sq} + {{(QUO_W+2-COORD_W+1){base[COORD_W-1]}}, base};
    if (sat_q) begin
      coord_val = neg_q ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else if (sum[QUO_W+2:COORD_W-1] != {(QUO_W+4-COORD_W){sum[QUO_W+2]}}) begin
      coord_val = sum[QUO_W+2] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      coord_val = sum[COORD_W-1:0];
    end
    ddx  = {x_q[COORD_W-1], x_q} - {rd_q[2*COORD_W-1], rd_q[2*COORD_W-1:COORD_W]};
    ddy  = {y_q[COORD_W-1], y_q} - {rd_q[COORD_W-1], rd_q[COORD_W-1:0]};
    dx2  = $signed(ddx[7:0]) * $signed(ddx[7:0]);
    dy2  = $signed(ddy[7:0]) * $signed(ddy[7:0]);
    d2   = {1'b0, dx2} + {1'b0, dy2};
    near = (ddx > -DUP_SPAN) && (ddx < DUP_SPAN) && (ddy > -DUP_SPAN) && (ddy < DUP_SPAN)
           && (d2 <= DUP_D2_MAX);
  end

  always_comb begin
    state_d = state_q;
    cur_x_d = cur_x_q;  cur_y_d = cur_y_q;  fin_d = fin_q;
    prior_x_d = prior_x_q;  prior_y_d = prior_y_q;
    first_x_d = first_x_q;  first_y_d = first_y_q;
    have_prior_d = have_prior_q;  edge_d = edge_q;  coord_d = coord_q;
    found_cnt_d = found_cnt_q;  idx_d = idx_q;  step_d = step_q;
    sx_d = sx_q;  sy_d = sy_q;  rx_d = rx_q;  ry_d = ry_q;  dx_d = dx_q;  dy_d = dy_q;
    r_d = r_q;  u_d = u_q;  t_d = t_q;  acc_d = acc_q;  n_d = n_q;
    nabs_d = nabs_q;  neg_d = neg_q;  sat_d = sat_q;
    rem_d = rem_q;  nlow_d = nlow_q;  quo_d = quo_q;  x_d = x_q;  y_d = y_q;
    mem_we = 1'b0;  mem_re = 1'b0;  mem_waddr = found_cnt_q[AW-1:0];
    out_valid_d = out_valid_q && !out_ready_i;
    ox_d = ox_q;  oy_d = oy_q;  pv_d = pv_q;  re_d = re_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cur_x_d = vertex_x_i;
          cur_y_d = vertex_y_i;
          fin_d   = final_vertex_i;
          if (!have_prior_q) begin
            first_x_d = vertex_x_i;
            first_y_d = vertex_y_i;
          end
          if (have_prior_q) begin
            edge_d  = 1'b0;
            state_d = S_SETUP;
          end else if (final_vertex_i) begin
            edge_d  = 1'b1;
            state_d = S_SETUP;
          end else begin
            prior_x_d    = vertex_x_i;
            prior_y_d    = vertex_y_i;
            have_prior_d = 1'b1;
          end
        end
      end
      S_SETUP: begin
        sx_d = {end_x_q[COORD_W-1], end_x_q} - {start_x_q[COORD_W-1], start_x_q};
        sy_d = {end_y_q[COORD_W-1], end_y_q} - {start_y_q[COORD_W-1], start_y_q};
        rx_d = {ce_x[COORD_W-1], ce_x} - {pe_x[COORD_W-1], pe_x};
        ry_d = {ce_y[COORD_W-1], ce_y} - {pe_y[COORD_W-1], pe_y};
        dx_d = {start_x_q[COORD_W-1], start_x_q} - {pe_x[COORD_W-1], pe_x};
        dy_d = {start_y_q[COORD_W-1], start_y_q} - {pe_y[COORD_W-1], pe_y};
        step_d  = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        case (step_q)
          6'd1: r_d = prod_x;
          6'd2: r_d = r_q - prod_x;
          6'd3: u_d = prod_x;
          6'd4: u_d = u_q - prod_x;
          6'd5: t_d = prod_x;
          6'd6: t_d = t_q - prod_x;
          default: ;
        endcase
        step_d = step_q + 6'd1;
        if (step_q == 6'd6) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        if (r_q[WIDE_W-1]) begin
          r_d = -r_q;
          u_d = -u_q;
          t_d = -t_q;
        end
        state_d = S_CHECK;
      end
      S_CHECK: begin
        step_d  = '0;
        coord_d = 1'b0;
        if (r_q < PARALLEL_MIN || t_q[WIDE_W-1] || t_q > r_q) begin
          state_d = S_EDGEEND;
        end else if (ray_q) begin
          acc_d   = '0;
          state_d = S_RAY;
        end else if (!u_q[WIDE_W-1] && u_q <= r_q) begin
          state_d = S_XMUL;
        end else begin
          state_d = S_EDGEEND;
        end
      end
      S_RAY: begin
        acc_d  = acc_q + term;
        step_d = step_q + 6'd1;
        if (step_q == 6'd6) begin
          state_d = S_RAYTST;
        end
      end
      S_RAYTST: begin
        step_d  = '0;
        state_d = (acc_q > 0) ? S_XMUL : S_EDGEEND;
      end
      S_XMUL: begin
        case (step_q)
          6'd1: n_d = {{(NUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
          6'd2: n_d = n_q + {{(NUM_W-PROD_W-32){prod_q[PROD_W-1]}}, prod_q, 32'd0};
          6'd3: n_d = n_q + {prod_q[NUM_W-65:0], 64'd0};
          default: ;
        endcase
        step_d = step_q + 6'd1;
        if (step_q == 6'd3) begin
          state_d = S_XABS;
        end
      end
      S_XABS: begin
        neg_d   = n_q[NUM_W-1];
        nabs_d  = n_q[NUM_W-1] ? (NUM_W-1)'(-n_q) : n_q[NUM_W-2:0];
        state_d = S_XSAT;
      end
      S_XSAT: begin
        sat_d  = {1'b0, nabs_q[NUM_W-2:QUO_W]} >= r_q[PROD_W-1:0];
        rem_d  = {1'b0, nabs_q[NUM_W-2:QUO_W]};
        nlow_d = nabs_q[QUO_W-1:0];
        quo_d  = '0;
        step_d = '0;
        state_d = ({1'b0, nabs_q[NUM_W-2:QUO_W]} >= r_q[PROD_W-1:0]) ? S_XFIN : S_XDIV;
      end
      S_XDIV: begin
        rem_d  = ge ? PROD_W'(rem2 - {1'b0, r_q[PROD_W-1:0]}) : rem2[PROD_W-1:0];
        quo_d  = {quo_q[QUO_W-2:0], ge};
        nlow_d = {nlow_q[QUO_W-2:0], 1'b0};
        step_d = step_q + 6'd1;
        if (step_q == 6'(QUO_W - 1)) begin
          state_d = S_XFIN;
        end
      end
      S_XFIN: begin
        step_d = '0;
        if (!coord_q) begin
          x_d     = coord_val;
          coord_d = 1'b1;
          state_d = S_XMUL;
        end else begin
          y_d     = coord_val;
          idx_d   = '0;
          state_d = S_DUPRD;
        end
      end
      S_DUPRD: begin
        if (idx_q == found_cnt_q) begin
          if (found_cnt_q < MAX_CNT) begin
            mem_we      = 1'b1;
            found_cnt_d = found_cnt_q + 1'b1;
          end
          state_d = S_EMIT;
        end else begin
          mem_re  = 1'b1;
          state_d = S_DUPCMP;
        end
      end
      S_DUPCMP: begin
        idx_d   = idx_q + 1'b1;
        state_d = near ? S_EDGEEND : S_DUPRD;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          ox_d = x_q;
          oy_d = y_q;
          pv_d = 1'b1;
          re_d = !fin_q;
          state_d = S_EDGEEND;
        end
      end
      S_EDGEEND: begin
        if (fin_q && !edge_q) begin
          edge_d  = 1'b1;
          state_d = S_SETUP;
        end else if (fin_q) begin
          state_d = S_MARK;
        end else begin
          prior_x_d    = cur_x_q;
          prior_y_d    = cur_y_q;
          have_prior_d = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_MARK: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          ox_d = '0;
          oy_d = '0;
          pv_d = 1'b0;
          re_d = 1'b1;
          have_prior_d = 1'b0;
          found_cnt_d  = '0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      have_prior_q <= 1'b0;
      found_cnt_q  <= '0;
      out_valid_q  <= 1'b0;
      prior_x_q    <= '0;
      prior_y_q    <= '0;
      first_x_q    <= '0;
      first_y_q    <= '0;
      fin_q        <= 1'b0;
      edge_q       <= 1'b0;
      coord_q      <= 1'b0;
      idx_q        <= '0;
      step_q       <= '0;
    end else begin
      state_q      <= state_d;
      have_prior_q <= have_prior_d;
      found_cnt_q  <= found_cnt_d;
      out_valid_q  <= out_valid_d;
      prior_x_q    <= prior_x_d;
      prior_y_q    <= prior_y_d;
      first_x_q    <= first_x_d;
      first_y_q    <= first_y_d;
      fin_q        <= fin_d;
      edge_q       <= edge_d;
      coord_q      <= coord_d;
      idx_q        <= idx_d;
      step_q       <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d;  cur_y_q <= cur_y_d;
    sx_q <= sx_d;  sy_q <= sy_d;  rx_q <= rx_d;  ry_q <= ry_d;  dx_q <= dx_d;  dy_q <= dy_d;
    r_q <= r_d;  u_q <= u_d;  t_q <= t_d;  acc_q <= acc_d;  n_q <= n_d;
    nabs_q <= nabs_d;  neg_q <= neg_d;  sat_q <= sat_d;
    rem_q <= rem_d;  nlow_q <= nlow_d;  quo_q <= quo_d;  x_q <= x_d;  y_q <= y_d;
    ox_q <= ox_d;  oy_q <= oy_d;  pv_q <= pv_d;  re_q <= re_d;
  end

  assign out_valid_o   = out_valid_q;
  assign cross_x_o     = ox_q;
  assign cross_y_o     = oy_q;
  assign point_valid_o = pv_q;
  assign run_end_o     = re_q;

  `SPC_ASSERT(a_cnt_bound, clk_i, rst_ni, found_cnt_q <= MAX_CNT)
  `SPC_ASSERT(a_r_nonneg, clk_i, rst_ni, (state_q != S_CHECK) || !r_q[WIDE_W-1])
  `SPC_ASSERT(a_rem_below, clk_i, rst_ni, (state_q != S_XDIV) || (rem_q < r_q[PROD_W-1:0]))
  `SPC_ASSERT_NEXT(a_mark_clear, clk_i, rst_ni, (state_q == S_MARK) && slot_free, (found_cnt_q == '0) && !have_prior_q && out_valid_q && !point_valid_o)

endmodule

// ----- tb/sv/tb_segment_polygon_crosspoints_unit.sv -----
// ----------------------------------------------------------------------------
// Testbench for the segment / polygon crosspoint unit
// Drives closed polygons vertex by vertex against several segment and ray
// settings, predicts every crosspoint and end marker with exact wide integer
// arithmetic, and compares each output transaction field by field.
// ----------------------------------------------------------------------------
typedef logic signed [127:0] wide_t;

typedef struct {
  logic signed [31:0] x;
  logic signed [31:0] y;
  bit                 pv;
  bit                 re;
} cross_t;

class crosspoint_scoreboard;
  localparam int STORE_DEPTH = 64;

  logic signed [31:0] seg_sx, seg_sy, seg_ex, seg_ey;
  bit                 ray_sel;
  logic signed [31:0] prev_x, prev_y, head_x, head_y;
  bit                 open_poly;
  logic signed [31:0] store_x[STORE_DEPTH];
  logic signed [31:0] store_y[STORE_DEPTH];
  int                 store_cnt;
  cross_t             expected_q[$];
  int                 errors;

  function new();
    seg_sx = 0; seg_sy = 0; seg_ex = 0; seg_ey = 0; ray_sel = 0;
    prev_x = 0; prev_y = 0; head_x = 0; head_y = 0;
    open_poly = 0; store_cnt = 0; errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      spc_pkg::CFG_START_X: seg_sx = val;
      spc_pkg::CFG_START_Y: seg_sy = val;
      spc_pkg::CFG_END_X:   seg_ex = val;
      spc_pkg::CFG_END_Y:   seg_ey = val;
      spc_pkg::CFG_RAY_SEL: ray_sel = val[0];
      default: ;
    endcase
  endfunction

  function wide_t scale_point(wide_t base, wide_t sv, wide_t num, wide_t den);
    wide_t n, q, rm;
    bit    neg;
    n = sv * num;
    neg = n < 0;
    if (neg) n = -n;
    q = n / den;
    rm = n % den;
    if (rm * 2 >= den) q = q + 1;
    if (neg) q = -q;
    q = q + base;
    if (q < -wide_t'(64'sh80000000)) q = -wide_t'(64'sh80000000);
    if (q > wide_t'(64'sh7fffffff)) q = wide_t'(64'sh7fffffff);
    return q;
  endfunction

  function void edge_hit(logic signed [31:0] px, logic signed [31:0] py,
                         logic signed [31:0] cx, logic signed [31:0] cy,
                         ref cross_t found_q[$]);
    wide_t  qx, qy, svx, svy, rx, ry, dx, dy, rr, uu, tt, xw, yw, ddx, ddy;
    bit     hit, dup;
    cross_t c;
    qx = seg_sx; qy = seg_sy;
    svx = wide_t'(seg_ex) - qx; svy = wide_t'(seg_ey) - qy;
    rx = wide_t'(cx) - wide_t'(px); ry = wide_t'(cy) - wide_t'(py);
    dx = qx - wide_t'(px); dy = qy - wide_t'(py);
    rr = rx * svy - ry * svx;
    uu = dx * ry - dy * rx;
    tt = dx * svy - dy * svx;
    if (rr < 0) begin
      rr = -rr; uu = -uu; tt = -tt;
    end
    if (rr < 430) return;
    if (tt < 0 || tt > rr) return;
    if (ray_sel) hit = uu * 100 > rr * 99;
    else hit = uu >= 0 && uu <= rr;
    if (!hit) return;
    xw = scale_point(qx, svx, uu, rr);
    yw = scale_point(qy, svy, uu, rr);
    dup = 0;
    for (int i = 0; i < store_cnt && i < STORE_DEPTH; i++) begin
      ddx = xw - wide_t'(store_x[i]);
      ddy = yw - wide_t'(store_y[i]);
      if (ddx > -7 && ddx < 7 && ddy > -7 && ddy < 7 && ddx * ddx + ddy * ddy <= 42)
        dup = 1;
    end
    if (dup) return;
    if (store_cnt < STORE_DEPTH) begin
      store_x[store_cnt] = xw[31:0];
      store_y[store_cnt] = yw[31:0];
      store_cnt++;
    end
    c.x = xw[31:0]; c.y = yw[31:0]; c.pv = 1; c.re = 0;
    found_q.insert(found_q.size(), c);
  endfunction

  function void note_vertex(logic signed [31:0] vx, logic signed [31:0] vy, bit fin);
    cross_t found_q[$];
    cross_t c;
    if (!open_poly) begin
      head_x = vx; head_y = vy;
    end else begin
      edge_hit(prev_x, prev_y, vx, vy, found_q);
    end
    if (fin) begin
      edge_hit(vx, vy, head_x, head_y, found_q);
      c.x = 0; c.y = 0; c.pv = 0; c.re = 0;
      found_q.insert(found_q.size(), c);
      open_poly = 0;
      store_cnt = 0;
    end else begin
      prev_x = vx; prev_y = vy; open_poly = 1;
    end
    if (found_q.size() > 0) found_q[found_q.size()-1].re = 1;
    foreach (found_q[i]) expected_q.insert(expected_q.size(), found_q[i]);
  endfunction

  function void check_result(cross_t got);
    cross_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected transaction x=%h y=%h pv=%0d re=%0d",
               $time, got.x, got.y, got.pv, got.re);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.x !== want.x) begin
      $display("%0t: cross_x expected %h actual %h", $time, want.x, got.x);
      errors++;
    end
    if (got.y !== want.y) begin
      $display("%0t: cross_y expected %h actual %h", $time, want.y, got.y);
      errors++;
    end
    if (got.pv !== want.pv) begin
      $display("%0t: point_valid expected %0d actual %0d", $time, want.pv, got.pv);
      errors++;
    end
    if (got.re !== want.re) begin
      $display("%0t: run_end expected %0d actual %0d", $time, want.re, got.re);
      errors++;
    end
  endfunction
endclass

module tb_segment_polygon_crosspoints_unit
  import spc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UNIT = 65536;

  logic                      clk_i = 0;
  logic                      rst_ni = 0;
  logic                      cfg_we_i = 0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i = '0;
  logic [COORD_W-1:0]        cfg_wdata_i = '0;
  logic                      in_valid_i = 0;
  logic                      in_ready_o;
  logic signed [COORD_W-1:0] vertex_x_i = '0;
  logic signed [COORD_W-1:0] vertex_y_i = '0;
  logic                      final_vertex_i = 0;
  logic                      out_valid_o;
  logic                      out_ready_i = 0;
  logic signed [COORD_W-1:0] cross_x_o, cross_y_o;
  logic                      point_valid_o, run_end_o;

  crosspoint_scoreboard sb = new();
  int  tx_idle_pct = 25;
  int  rx_idle_pct = 66;
  int  sent = 0;

  segment_polygon_crosspoints_unit dut (.*);

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) out_ready_i = ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk_i) begin
    cross_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.x = cross_x_o; got.y = cross_y_o; got.pv = point_valid_o; got.re = run_end_o;
      sb.check_result(got);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i = 1; cfg_idx_i = idx; cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_segment(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                             logic [31:0] by, bit ray);
    write_reg(CFG_START_X, ax);
    write_reg(CFG_START_Y, ay);
    write_reg(CFG_END_X, bx);
    write_reg(CFG_END_Y, by);
    write_reg(CFG_RAY_SEL, {31'b0, ray});
  endtask

  task automatic send_vertex(logic signed [31:0] vx, logic signed [31:0] vy, bit fin);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i = 1; vertex_x_i = vx; vertex_y_i = vy; final_vertex_i = fin;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_vertex(vx, vy, fin);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] near_coord();
    return $signed($urandom_range(20 * UNIT)) - 10 * UNIT;
  endfunction

  task automatic zigzag_polygon();
    int                 n;
    logic signed [63:0] ax, ay, svx, svy, px, py;
    // Zigzag along the segment so that the point store overflows.
    ax = sb.seg_sx; ay = sb.seg_sy;
    svx = 64'(sb.seg_ex) - ax; svy = 64'(sb.seg_ey) - ay;
    n = $urandom_range(66, 72);
    for (int i = 0; i <= n; i++) begin
      px = ax + svx * i / n + ((i % 2) ? -svy : svy) / 8;
      py = ay + svy * i / n + ((i % 2) ? svx : -svx) / 8;
      send_vertex(px[31:0], py[31:0], i == n);
    end
  endtask

  task automatic random_polygon();
    int kind, n;
    kind = $urandom_range(1, 19);
    if (kind <= 2) begin
      n = $urandom_range(2, 4);
      for (int i = 0; i < n; i++) send_vertex($urandom, $urandom, i == n - 1);
    end else if (kind == 3) begin
      send_vertex(near_coord(), near_coord(), 1'b1);
    end else begin
      n = $urandom_range(3, 8);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(7))
          0: send_vertex(sb.seg_sx, sb.seg_sy, i == n - 1);
          1: send_vertex(sb.seg_ex, sb.seg_ey, i == n - 1);
          default: send_vertex(near_coord(), near_coord(), i == n - 1);
        endcase
      end
    end
  endtask

  task automatic random_setting(int which);
    case (which)
      0: set_segment(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                     1'($urandom_range(1)));
      1: set_segment(near_coord(), near_coord(), near_coord(), near_coord(), 1'b1);
      default: set_segment(near_coord(), near_coord(), near_coord(), near_coord(), 1'b0);
    endcase
  endtask

  initial begin
    int target;
    repeat (8) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    set_segment(0, 0, 4 * UNIT, 0, 1'b0);
    send_vertex(1 * UNIT, -1 * UNIT, 1'b0);
    send_vertex(3 * UNIT, -1 * UNIT, 1'b0);
    send_vertex(3 * UNIT, 1 * UNIT, 1'b0);
    send_vertex(1 * UNIT, 1 * UNIT, 1'b1);
    send_vertex(2 * UNIT, 0, 1'b0);
    send_vertex(3 * UNIT, 1 * UNIT, 1'b0);
    send_vertex(3 * UNIT, -1 * UNIT, 1'b1);
    send_vertex(1 * UNIT, 0, 1'b0);
    send_vertex(3 * UNIT, 0, 1'b0);
    send_vertex(2 * UNIT, 1 * UNIT, 1'b1);
    send_vertex(5 * UNIT, 5 * UNIT, 1'b1);
    send_vertex(32'sh80000000, 32'sh80000000, 1'b0);
    send_vertex(32'sh7fffffff, 32'sh80000000, 1'b0);
    send_vertex(32'sh7fffffff, 32'sh7fffffff, 1'b0);
    send_vertex(32'sh80000000, 32'sh7fffffff, 1'b1);
    zigzag_polygon();
    drain();
    set_segment(0, 0, 4 * UNIT, 0, 1'b1);
    send_vertex(10 * UNIT, -1 * UNIT, 1'b0);
    send_vertex(12 * UNIT, -1 * UNIT, 1'b0);
    send_vertex(12 * UNIT, 1 * UNIT, 1'b0);
    send_vertex(10 * UNIT, 1 * UNIT, 1'b1);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 66 : 0;
      rx_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 25 : 0;
      for (int st = 0; st < 3; st++) begin
        random_setting(st);
        target = sent + 17;
        while (sent < target) random_polygon();
        drain();
      end
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("tb_segment_polygon_crosspoints_unit: done, clean");
    else
      $display("tb_segment_polygon_crosspoints_unit: done, errors");
    $finish;
  end

  initial begin
    #30ms;
    $display("tb_segment_polygon_crosspoints_unit: done, errors");
    $finish;
  end
endmodule
